// ===== hdl/tbacc_pkg.sv =====
package tbacc_pkg;

  localparam int unsigned MemDepth = 4096;
  localparam int unsigned WordW    = 12;
  localparam int unsigned AddrW    = 12;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [AddrW-1:0]   address;
    word_t              data;
  } in_word_t;

  typedef struct packed {
    word_t pc;
    word_t acc;
    logic  carry;
    logic  zero;
    logic  halted;
    word_t read_data;
  } out_word_t;

  typedef struct packed {
    logic [2:0] cnd;
    logic [2:0] op1;
    logic [2:0] op2;
    logic [2:0] rs1;
  } inst_t;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_IN_LATCH,
    UOP_MEM_WR_IN,
    UOP_MEM_RD_IN,
    UOP_CLEAR,
    UOP_FETCH,
    UOP_DECODE,
    UOP_OPF_REG,
    UOP_PC_INC_RD,
    UOP_RD_PC,
    UOP_MP_RD,
    UOP_MP_RD_IDX,
    UOP_SP_POP,
    UOP_OPND_LD,
    UOP_SKIP,
    UOP_LOAD_OPND,
    UOP_MP_OPND_RD,
    UOP_MP_OPND_RD_IDX,
    UOP_LD_RDATA,
    UOP_MP_WR,
    UOP_MP_WR_IDX,
    UOP_SP_PUSH,
    UOP_MV_STORE,
    UOP_MV_STORE_IDX,
    UOP_ALU,
    UOP_MSC,
    UOP_INCDEC,
    UOP_RET1,
    UOP_RET2,
    UOP_PC_FINAL,
    UOP_RESULT
  } uop_e;

  typedef struct packed {
    inst_t ir;
    logic  cond_ok;
    logic  out_free;
    cmd_e  cmd;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DECODE,
    ST_OPF,
    ST_OPF_MP,
    ST_OPF_MPX,
    ST_OPND_LD,
    ST_EXEC,
    ST_LOADR,
    ST_ST_MP,
    ST_ST_MPX,
    ST_LD_RDATA,
    ST_RET2,
    ST_END,
    ST_FIN
  } state_e;

  // Register selector for the low two bits of a register field.
  localparam logic [1:0] RegAcc = 2'd0;
  localparam logic [1:0] RegB   = 2'd1;
  localparam logic [1:0] RegIdx = 2'd2;
  localparam logic [1:0] RegSp  = 2'd3;

  localparam logic [2:0] ModeImm  = 3'd4;
  localparam logic [2:0] ModeDir  = 3'd5;
  localparam logic [2:0] ModeIdx  = 3'd6;
  localparam logic [2:0] ModeStk  = 3'd7;

  localparam logic [3:0] MscJmp  = 4'd0;
  localparam logic [3:0] MscHalt = 4'd1;
  localparam logic [3:0] MscCall = 4'd2;
  localparam logic [3:0] MscRet  = 4'd3;
  localparam logic [3:0] MscDec  = 4'd4;
  localparam logic [3:0] MscInc  = 4'd5;
  localparam logic [3:0] MscCmpA = 4'd8;
  localparam logic [3:0] MscCmpO = 4'd9;
  localparam logic [3:0] MscXor  = 4'd10;
  localparam logic [3:0] MscXnor = 4'd11;
  localparam logic [3:0] MscClc  = 4'd12;
  localparam logic [3:0] MscClz  = 4'd13;
  localparam logic [3:0] MscStc  = 4'd14;
  localparam logic [3:0] MscStz  = 4'd15;

endpackage

// ===== hdl/twelve_bit_accumulator_cpu_core.sv =====
// Twelve-bit accumulator core with a 4096-word shared program/data memory.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command word:
// execute the instruction at pc, write a memory word, read a memory word,
// or clear the core registers. Each command yields one result word on the
// output channel (out_valid_o/out_ready_i/out_data_o) with pc, acc, flags,
// halt and, for reads, the memory word.
// The configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) is always
// ready and loads the 32-bit condition table; the user must write it only
// while idle, which the block does not enforce. Memory and clear commands
// go from dispatch to the final state; execute steps through decode, operand
// and execute states on the memory port: fetch, reads, a write-back, one
// access per cycle. One command is in flight at a time, and the next word
// is accepted the cycle after the result is loaded into the output register.
// When the receiver stalls, the result waits in the output register and the
// controller holds in its final state until the register frees up.
// Reset clears all core registers and flags and sets the condition table
// to all ones; memory contents are undefined until written.
module twelve_bit_accumulator_cpu_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tbacc_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tbacc_pkg::out_word_t out_data_o
);

  tbacc_pkg::status_t status;
  tbacc_pkg::uop_e    uop;

  assign cfg_ready_o = 1'b1;

  tbacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .uop_o      (uop)
  );

  tbacc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .uop_i       (uop),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/tbacc_ctrl.sv =====
module tbacc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tbacc_pkg::status_t status_i,
  output tbacc_pkg::uop_e   uop_o
);

  tbacc_pkg::state_e state_q, state_d;
  logic [2:0] dest;
  logic [2:0] move_sel;
  logic [3:0] msc_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbacc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Moves store into op2, increment and decrement store back through rs1.
  assign dest     = (status_i.ir.op1[2] == 1'b0) ? status_i.ir.op2 : status_i.ir.rs1;
  assign move_sel = {status_i.ir.op1[1:0], status_i.ir.op2[2]};
  assign msc_sel  = {status_i.ir.op1[0], status_i.ir.op2};

  always_comb begin
    state_d    = state_q;
    uop_o      = tbacc_pkg::UOP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      tbacc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          uop_o   = tbacc_pkg::UOP_IN_LATCH;
          state_d = tbacc_pkg::ST_DISPATCH;
        end
      end
      tbacc_pkg::ST_DISPATCH: begin
        unique case (status_i.cmd)
          tbacc_pkg::CMD_EXEC: begin
            uop_o   = tbacc_pkg::UOP_FETCH;
            state_d = tbacc_pkg::ST_DECODE;
          end
          tbacc_pkg::CMD_WRITE: begin
            uop_o   = tbacc_pkg::UOP_MEM_WR_IN;
            state_d = tbacc_pkg::ST_FIN;
          end
          tbacc_pkg::CMD_READ: begin
            uop_o   = tbacc_pkg::UOP_MEM_RD_IN;
            state_d = tbacc_pkg::ST_FIN;
          end
          default: begin
            uop_o   = tbacc_pkg::UOP_CLEAR;
            state_d = tbacc_pkg::ST_FIN;
          end
        endcase
      end
      tbacc_pkg::ST_DECODE: begin
        uop_o   = tbacc_pkg::UOP_DECODE;
        state_d = tbacc_pkg::ST_OPF;
      end
      tbacc_pkg::ST_OPF: begin
        unique case (status_i.ir.rs1)
          tbacc_pkg::ModeImm: begin
            uop_o   = tbacc_pkg::UOP_PC_INC_RD;
            state_d = tbacc_pkg::ST_OPND_LD;
          end
          tbacc_pkg::ModeDir: begin
            uop_o   = tbacc_pkg::UOP_PC_INC_RD;
            state_d = tbacc_pkg::ST_OPF_MP;
          end
          tbacc_pkg::ModeIdx: begin
            uop_o   = tbacc_pkg::UOP_PC_INC_RD;
            state_d = tbacc_pkg::ST_OPF_MPX;
          end
          tbacc_pkg::ModeStk: begin
            uop_o   = tbacc_pkg::UOP_SP_POP;
            state_d = tbacc_pkg::ST_OPND_LD;
          end
          default: begin
            uop_o   = tbacc_pkg::UOP_OPF_REG;
            state_d = tbacc_pkg::ST_EXEC;
          end
        endcase
      end
      tbacc_pkg::ST_OPF_MP: begin
        uop_o   = tbacc_pkg::UOP_MP_RD;
        state_d = tbacc_pkg::ST_OPND_LD;
      end
      tbacc_pkg::ST_OPF_MPX: begin
        uop_o   = tbacc_pkg::UOP_MP_RD_IDX;
        state_d = tbacc_pkg::ST_OPND_LD;
      end
      tbacc_pkg::ST_OPND_LD: begin
        uop_o   = tbacc_pkg::UOP_OPND_LD;
        state_d = tbacc_pkg::ST_EXEC;
      end
      tbacc_pkg::ST_EXEC: begin
        state_d = tbacc_pkg::ST_END;
        if (!status_i.cond_ok) begin
          // A failed move skips its destination operand word.
          if (!status_i.ir.op1[2] && status_i.ir.op2[2] &&
              (status_i.ir.op2 != tbacc_pkg::ModeStk)) begin
            uop_o = tbacc_pkg::UOP_SKIP;
          end
        end else if (!status_i.ir.op1[2]) begin
          case (move_sel)
            3'd0, 3'd1: state_d = tbacc_pkg::ST_LOADR;
            3'd2: begin
              uop_o   = tbacc_pkg::UOP_MP_OPND_RD;
              state_d = tbacc_pkg::ST_LD_RDATA;
            end
            3'd3: begin
              uop_o   = tbacc_pkg::UOP_MP_OPND_RD_IDX;
              state_d = tbacc_pkg::ST_LD_RDATA;
            end
            3'd4: uop_o = tbacc_pkg::UOP_MV_STORE;
            3'd5: uop_o = tbacc_pkg::UOP_MV_STORE_IDX;
            default: uop_o = tbacc_pkg::UOP_NONE;
          endcase
        end else if (!status_i.ir.op1[1]) begin
          uop_o = tbacc_pkg::UOP_ALU;
        end else begin
          case (msc_sel)
            tbacc_pkg::MscRet: begin
              uop_o   = tbacc_pkg::UOP_RET1;
              state_d = tbacc_pkg::ST_RET2;
            end
            tbacc_pkg::MscDec, tbacc_pkg::MscInc: begin
              uop_o   = tbacc_pkg::UOP_INCDEC;
              state_d = tbacc_pkg::ST_LOADR;
            end
            default: uop_o = tbacc_pkg::UOP_MSC;
          endcase
        end
      end
      tbacc_pkg::ST_LOADR: begin
        state_d = tbacc_pkg::ST_END;
        unique case (dest)
          tbacc_pkg::ModeImm: begin
            uop_o   = tbacc_pkg::UOP_RD_PC;
            state_d = tbacc_pkg::ST_ST_MP;
          end
          tbacc_pkg::ModeDir: begin
            uop_o   = tbacc_pkg::UOP_PC_INC_RD;
            state_d = tbacc_pkg::ST_ST_MP;
          end
          tbacc_pkg::ModeIdx: begin
            uop_o   = tbacc_pkg::UOP_PC_INC_RD;
            state_d = tbacc_pkg::ST_ST_MPX;
          end
          tbacc_pkg::ModeStk: uop_o = tbacc_pkg::UOP_SP_PUSH;
          default:            uop_o = tbacc_pkg::UOP_LOAD_OPND;
        endcase
      end
      tbacc_pkg::ST_ST_MP: begin
        uop_o   = tbacc_pkg::UOP_MP_WR;
        state_d = tbacc_pkg::ST_END;
      end
      tbacc_pkg::ST_ST_MPX: begin
        uop_o   = tbacc_pkg::UOP_MP_WR_IDX;
        state_d = tbacc_pkg::ST_END;
      end
      tbacc_pkg::ST_LD_RDATA: begin
        uop_o   = tbacc_pkg::UOP_LD_RDATA;
        state_d = tbacc_pkg::ST_END;
      end
      tbacc_pkg::ST_RET2: begin
        uop_o   = tbacc_pkg::UOP_RET2;
        state_d = tbacc_pkg::ST_END;
      end
      tbacc_pkg::ST_END: begin
        uop_o   = tbacc_pkg::UOP_PC_FINAL;
        state_d = tbacc_pkg::ST_FIN;
      end
      tbacc_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          uop_o   = tbacc_pkg::UOP_RESULT;
          state_d = tbacc_pkg::ST_IDLE;
        end
      end
      default: state_d = tbacc_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted while busy");
  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tbacc_pkg::ST_FIN && !status_i.out_free) |=> (state_q == tbacc_pkg::ST_FIN))
    else $error("result dropped while output full");
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_o == tbacc_pkg::UOP_RESULT) |=> (uop_o != tbacc_pkg::UOP_RESULT))
    else $error("result issued twice");
`endif

endmodule

// ===== hdl/tbacc_dpath.sv =====
module tbacc_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [31:0]          cfg_data_i,
  input  tbacc_pkg::in_word_t  in_data_i,
  input  tbacc_pkg::uop_e      uop_i,
  output tbacc_pkg::status_t   status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tbacc_pkg::out_word_t out_data_o
);

  tbacc_pkg::word_t mem_q [tbacc_pkg::MemDepth];
  tbacc_pkg::word_t rdata_q;

  logic [31:0] cond_table_q;
  tbacc_pkg::word_t acc_q, acc_d, b_q, b_d, idx_q, idx_d, sp_q, sp_d;
  tbacc_pkg::word_t pc_q, pc_d, opnd_q, opnd_d;
  logic halt_q, halt_d, c_q, c_d, z_q, z_d;
  tbacc_pkg::inst_t ir_q, ir_d;
  tbacc_pkg::cmd_e cmd_q, cmd_d;
  tbacc_pkg::word_t addr_q, addr_d, data_q, data_d;
  tbacc_pkg::out_word_t out_q, out_d;
  logic outv_q, outv_d;

  logic mem_we, mem_re;
  tbacc_pkg::word_t mem_addr, mem_wdata;
  logic cond_ok;
  logic [1:0] dest;
  logic wr_en;
  logic [1:0] wr_sel;
  tbacc_pkg::word_t wr_val;
  logic [12:0] a13, o13, r13;
  logic [11:0] rl;
  logic [3:0] sel;

  function automatic tbacc_pkg::word_t reg_pick(input logic [1:0] s,
                                                input tbacc_pkg::word_t a,
                                                input tbacc_pkg::word_t b,
                                                input tbacc_pkg::word_t x,
                                                input tbacc_pkg::word_t p);
    case (s)
      tbacc_pkg::RegAcc: return a;
      tbacc_pkg::RegB:   return b;
      tbacc_pkg::RegIdx: return x;
      default:           return p;
    endcase
  endfunction

  assign cond_ok  = cond_table_q[{ir_q.cnd, z_q, c_q}] && !halt_q;
  assign dest     = (ir_q.op1[2] == 1'b0) ? ir_q.op2[1:0] : ir_q.rs1[1:0];
  assign sel      = {ir_q.op1[0], ir_q.op2};
  assign a13      = {1'b0, acc_q};
  assign o13      = {1'b0, opnd_q};

  assign status_o.ir       = ir_q;
  assign status_o.cond_ok  = cond_ok;
  assign status_o.out_free = !outv_q || out_ready_i;
  assign status_o.cmd      = cmd_q;
  assign out_valid_o       = outv_q;
  assign out_data_o        = out_q;

  always_comb begin
    acc_d = acc_q; b_d = b_q; idx_d = idx_q; sp_d = sp_q; pc_d = pc_q;
    opnd_d = opnd_q; halt_d = halt_q; c_d = c_q; z_d = z_q; ir_d = ir_q;
    cmd_d = cmd_q; addr_d = addr_q; data_d = data_q;
    out_d = out_q;
    outv_d = outv_q && !out_ready_i;
    mem_we = 1'b0; mem_re = 1'b0; mem_addr = pc_q; mem_wdata = opnd_q;
    wr_en = 1'b0; wr_sel = dest; wr_val = opnd_q;
    r13 = '0; rl = '0;
    case (uop_i)
      tbacc_pkg::UOP_IN_LATCH: begin
        cmd_d  = in_data_i.command;
        addr_d = in_data_i.address;
        data_d = in_data_i.data;
      end
      tbacc_pkg::UOP_MEM_WR_IN: begin
        mem_we = 1'b1; mem_addr = addr_q; mem_wdata = data_q;
      end
      tbacc_pkg::UOP_MEM_RD_IN: begin
        mem_re = 1'b1; mem_addr = addr_q;
      end
      tbacc_pkg::UOP_CLEAR: begin
        acc_d = '0; b_d = '0; idx_d = '0; sp_d = '0; pc_d = '0; opnd_d = '0;
        halt_d = 1'b0; c_d = 1'b0; z_d = 1'b0;
      end
      tbacc_pkg::UOP_FETCH: begin
        mem_re = 1'b1; mem_addr = pc_q;
      end
      tbacc_pkg::UOP_DECODE: ir_d = rdata_q;
      tbacc_pkg::UOP_OPF_REG: opnd_d = reg_pick(ir_q.rs1[1:0], acc_q, b_q, idx_q, sp_q);
      tbacc_pkg::UOP_PC_INC_RD: begin
        pc_d = pc_q + 12'd1; mem_re = 1'b1; mem_addr = pc_q + 12'd1;
      end
      tbacc_pkg::UOP_RD_PC: begin
        mem_re = 1'b1; mem_addr = pc_q;
      end
      tbacc_pkg::UOP_MP_RD: begin
        mem_re = 1'b1; mem_addr = rdata_q;
      end
      tbacc_pkg::UOP_MP_RD_IDX: begin
        mem_re = 1'b1; mem_addr = rdata_q + idx_q;
      end
      tbacc_pkg::UOP_SP_POP: begin
        mem_re = 1'b1;
        if (cond_ok) begin
          sp_d = sp_q + 12'd1; mem_addr = sp_q + 12'd1;
        end else begin
          mem_addr = sp_q;
        end
      end
      tbacc_pkg::UOP_OPND_LD: opnd_d = rdata_q;
      tbacc_pkg::UOP_SKIP: pc_d = pc_q + 12'd1;
      tbacc_pkg::UOP_LOAD_OPND: wr_en = 1'b1;
      tbacc_pkg::UOP_MP_OPND_RD: begin
        mem_re = 1'b1; mem_addr = opnd_q;
      end
      tbacc_pkg::UOP_MP_OPND_RD_IDX: begin
        mem_re = 1'b1; mem_addr = opnd_q + idx_q;
      end
      tbacc_pkg::UOP_LD_RDATA: begin
        wr_en = 1'b1; wr_sel = ir_q.op2[1:0]; wr_val = rdata_q;
      end
      tbacc_pkg::UOP_MP_WR: begin
        mem_we = 1'b1; mem_addr = rdata_q;
      end
      tbacc_pkg::UOP_MP_WR_IDX: begin
        mem_we = 1'b1; mem_addr = rdata_q + idx_q;
      end
      tbacc_pkg::UOP_SP_PUSH: begin
        mem_we = 1'b1;
        if (cond_ok) begin
          sp_d = sp_q - 12'd1; mem_addr = sp_q - 12'd1;
        end else begin
          mem_addr = sp_q;
        end
      end
      tbacc_pkg::UOP_MV_STORE, tbacc_pkg::UOP_MV_STORE_IDX: begin
        mem_we    = 1'b1;
        mem_addr  = (uop_i == tbacc_pkg::UOP_MV_STORE) ? opnd_q : opnd_q + idx_q;
        mem_wdata = reg_pick(ir_q.op2[1:0], acc_q, b_q, idx_q, sp_q);
        opnd_d    = mem_wdata;
      end
      tbacc_pkg::UOP_ALU: begin
        case (sel)
          4'd0: r13 = a13 + o13;
          4'd1: r13 = a13 + o13 + {12'd0, c_q};
          4'd2: r13 = a13 - o13;
          4'd3: r13 = a13 - o13 - {12'd0, c_q};
          4'd4: r13 = o13 - a13;
          4'd5: r13 = o13 - a13 - {12'd0, c_q};
          4'd6: r13 = 13'd0 - a13 - o13 - 13'd1;
          4'd7: r13 = 13'd0 - a13 - o13 - {12'd0, c_q} - 13'd1;
          4'd8: r13 = {1'b0, ~(acc_q & opnd_q)};
          4'd9: r13 = {1'b0, acc_q & opnd_q};
          4'd10: r13 = {1'b0, ~(acc_q & ~opnd_q)};
          4'd11: r13 = {1'b0, acc_q & ~opnd_q};
          4'd12: r13 = {1'b0, ~(~acc_q & opnd_q)};
          4'd13: r13 = {1'b0, ~acc_q & opnd_q};
          4'd14: r13 = {1'b0, ~(~acc_q & ~opnd_q)};
          default: r13 = {1'b0, ~acc_q & ~opnd_q};
        endcase
        if (!sel[3]) c_d = r13[12];
        acc_d = r13[11:0];
        z_d   = (r13[11:0] == 12'd0);
      end
      tbacc_pkg::UOP_MSC: begin
        case (sel)
          tbacc_pkg::MscJmp:  pc_d = opnd_q - 12'd1;
          tbacc_pkg::MscHalt: halt_d = 1'b1;
          tbacc_pkg::MscCall: begin
            sp_d = sp_q - 12'd1; mem_we = 1'b1; mem_addr = sp_q - 12'd1;
            mem_wdata = pc_q; pc_d = opnd_q - 12'd1;
          end
          tbacc_pkg::MscCmpA, tbacc_pkg::MscCmpO: begin
            r13 = (sel == tbacc_pkg::MscCmpA) ? a13 - o13 : o13 - a13;
            c_d = r13[12];
            z_d = (r13[11:0] == 12'd0);
          end
          tbacc_pkg::MscXor:  acc_d = acc_q ^ opnd_q;
          tbacc_pkg::MscXnor: acc_d = ~(acc_q ^ opnd_q);
          tbacc_pkg::MscClc:  c_d = 1'b0;
          tbacc_pkg::MscClz:  z_d = 1'b0;
          tbacc_pkg::MscStc:  c_d = 1'b1;
          tbacc_pkg::MscStz:  z_d = 1'b1;
          default: ;
        endcase
      end
      tbacc_pkg::UOP_INCDEC: begin
        r13 = sel[0] ? o13 + 13'd1 : o13 - 13'd1;
        rl  = r13[11:0];
        c_d = r13[12];
        opnd_d = rl;
        z_d = (rl == 12'd0);
        // Memory destinations re-read their operand word, so step pc back.
        if (ir_q.rs1[2] && ir_q.rs1 != tbacc_pkg::ModeStk) pc_d = pc_q - 12'd1;
      end
      tbacc_pkg::UOP_RET1: begin
        mem_re = 1'b1; mem_addr = sp_q;
      end
      tbacc_pkg::UOP_RET2: begin
        pc_d = rdata_q; sp_d = sp_q + 12'd1;
      end
      tbacc_pkg::UOP_PC_FINAL: if (!halt_q) pc_d = pc_q + 12'd1;
      tbacc_pkg::UOP_RESULT: begin
        out_d.pc        = pc_q;
        out_d.acc       = acc_q;
        out_d.carry     = c_q;
        out_d.zero      = z_q;
        out_d.halted    = halt_q;
        out_d.read_data = (cmd_q == tbacc_pkg::CMD_READ) ? rdata_q : 12'd0;
        outv_d          = 1'b1;
      end
      default: ;
    endcase
    if (wr_en) begin
      case (wr_sel)
        tbacc_pkg::RegAcc: acc_d = wr_val;
        tbacc_pkg::RegB:   b_d   = wr_val;
        tbacc_pkg::RegIdx: idx_d = wr_val;
        default:           sp_d  = wr_val;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_table_q <= 32'hFFFF_FFFF;
      acc_q <= '0; b_q <= '0; idx_q <= '0; sp_q <= '0; pc_q <= '0; opnd_q <= '0;
      halt_q <= 1'b0; c_q <= 1'b0; z_q <= 1'b0;
      ir_q <= '0;
      cmd_q <= tbacc_pkg::CMD_EXEC;
      outv_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cond_table_q <= cfg_data_i;
      end
      acc_q <= acc_d; b_q <= b_d; idx_q <= idx_d; sp_q <= sp_d; pc_q <= pc_d;
      opnd_q <= opnd_d; halt_q <= halt_d; c_q <= c_d; z_q <= z_d;
      ir_q <= ir_d;
      cmd_q <= cmd_d;
      outv_q <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    data_q <= data_d;
    out_q  <= out_d;
  end

`ifndef SYNTHESIS
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !mem_re)
    else $error("memory read and write in one cycle");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uop_i == tbacc_pkg::UOP_RESULT) |=> outv_q)
    else $error("result not presented");
  a_halt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halt_q) |-> $past(uop_i == tbacc_pkg::UOP_MSC))
    else $error("halt set outside halt instruction");
`endif

endmodule
